// ===== rtl/rgc_pkg.sv =====
// Shared constants for the RNS Garner coefficient unit: default sizes,
// result field widths and error codes. No dependencies.
package rgc_pkg;

   localparam int MAX_MODULI    = 64;
   localparam int MODULUS_WIDTH = 16;

   localparam int POS_WIDTH = 6;
   localparam int ERR_WIDTH = 2;

   localparam logic [ERR_WIDTH-1:0] ERR_OK         = 2'd0;
   localparam logic [ERR_WIDTH-1:0] ERR_NO_INVERSE = 2'd1;
   localparam logic [ERR_WIDTH-1:0] ERR_STORE_FULL = 2'd2;

endpackage

// ===== rtl/rgc_req_if.sv =====
// Request channel of the RNS Garner coefficient unit: valid/ready plus one modulus.
// Depends on rgc_pkg for the default modulus width.
interface rgc_req_if #(
   parameter int MODULUS_WIDTH = rgc_pkg::MODULUS_WIDTH
) ();
   logic                     valid;
   logic                     ready;
   logic [MODULUS_WIDTH-1:0] modulus;
   logic                     start_req;

   modport source (output valid, output modulus, output start_req, input ready);
   modport sink   (input valid, input modulus, input start_req, output ready);
endinterface

// ===== rtl/rgc_rsp_if.sv =====
// Response channel of the RNS Garner coefficient unit: valid/ready plus one result.
// Depends on rgc_pkg for field widths.
interface rgc_rsp_if #(
   parameter int MODULUS_WIDTH = rgc_pkg::MODULUS_WIDTH
) ();
   logic                           valid;
   logic                           ready;
   logic [MODULUS_WIDTH-1:0]       reciprocal;
   logic [rgc_pkg::POS_WIDTH-1:0]  position;
   logic [rgc_pkg::ERR_WIDTH-1:0]  error;

   modport source (output valid, output reciprocal, output position, output error,
                   input ready);
   modport sink   (input valid, input reciprocal, input position, input error,
                   output ready);
endinterface

// ===== rtl/rgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgc_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rns_garner_coefficients_top.sv =====
// Top level of the RNS Garner coefficient unit: sequencer, shared divider and multiplier.
// Depends on rgc_pkg, rgc_req_if, rgc_rsp_if and rgc_ram.

// Moduli of a residue number system arrive one transaction at a time on the
// request channel and are kept in an on-chip modulus store of MAX_MODULI
// entries. For the k-th modulus p of the current system the unit returns the
// mixed-radix coefficient (p_0 * ... * p_{k-1})^-1 mod p together with k as
// its position. A request with start_req set empties the store first, so its
// modulus becomes position 0, which always returns 0 with no error. A zero
// modulus at a later position, or a product that shares a factor with p,
// returns 0 with the no-inverse error; the modulus is still stored. When the
// store is full the modulus is dropped and the result carries position 0 and
// the store-full error. One transaction is in work at a time: the request
// side is ready only while the sequencer is idle, but a finished result sits
// in an output register, so the next request is taken while it waits. With
// W = MODULUS_WIDTH: position 0, a full store and a zero modulus go from
// idle straight to the done state. Position k folds the stored moduli into
// the product one by one, then runs extended Euclid steps (at most about
// 1.5*W steps), then finishes with a final remainder check, sign fix, range
// check and hand-off. Both phases run on one restoring divider that retires
// one quotient bit per cycle (2W steps to reduce a product, W steps per
// Euclid quotient) and one multiplier.
module rns_garner_coefficients_top #(
   parameter int MAX_MODULI    = rgc_pkg::MAX_MODULI
) (
   input  logic      clock,
   input  logic      reset,
   rgc_req_if.sink   req_chan,
   rgc_rsp_if.source rsp_chan
);

   localparam int W          = rgc_pkg::MODULUS_WIDTH;
   localparam int AddrWidth  = $clog2(MAX_MODULI);
   localparam int CountWidth = $clog2(MAX_MODULI + 1);
   localparam int DivWidth   = 2 * W;            // dividend width of the shared divider
   localparam int StepWidth  = $clog2(DivWidth + 1);
   localparam int TWidth     = W + 2;            // signed Bezout coefficient, |t| <= p
   localparam int ProdWidth  = W + 1 + TWidth;   // multiplier result width
   localparam int PosWidth   = rgc_pkg::POS_WIDTH;
   localparam int ErrWidth   = rgc_pkg::ERR_WIDTH;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_RLOAD = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_RDONE = 4'd5;
   localparam logic [3:0] S_EUCHK = 4'd6;
   localparam logic [3:0] S_EUMUL = 4'd7;
   localparam logic [3:0] S_EUUPD = 4'd8;
   localparam logic [3:0] S_FIN1  = 4'd9;
   localparam logic [3:0] S_FIN2  = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [3:0]                state_ff,  state_in;
   logic [CountWidth-1:0]     count_ff,  count_in;   // moduli held in the store
   logic [CountWidth-1:0]     k_ff,      k_in;       // position of the current modulus
   logic [W-1:0]              p_ff,      p_in;       // current modulus
   logic [CountWidth-1:0]     idx_ff,    idx_in;     // store entry being folded in
   logic [W-1:0]              prod_ff,   prod_in;    // running product mod p
   logic signed [ProdWidth-1:0] mult_ff, mult_in;
   logic [DivWidth-1:0]       dq_ff,     dq_in;      // dividend shifting out, quotient in
   logic [W-1:0]              rem_ff,    rem_in;
   logic [StepWidth-1:0]      dcnt_ff,   dcnt_in;
   logic                      phase_ff,  phase_in;   // 1: divider serves Euclid
   logic [W-1:0]              r0_ff,     r0_in;
   logic [W-1:0]              r1_ff,     r1_in;
   logic signed [TWidth-1:0]  t0_ff,     t0_in;
   logic signed [TWidth-1:0]  t1_ff,     t1_in;
   logic [W-1:0]              res_recip_ff, res_recip_in;
   logic [ErrWidth-1:0]       res_err_ff,   res_err_in;
   logic                      out_valid_ff, out_valid_in;
   logic [W-1:0]              out_recip_ff, out_recip_in;
   logic [PosWidth-1:0]       out_pos_ff,   out_pos_in;
   logic [ErrWidth-1:0]       out_err_ff,   out_err_in;

   // ------------------------------------------------------------------
   // Modulus store
   // ------------------------------------------------------------------
   logic                  wr_en;
   logic [AddrWidth-1:0]  wr_addr;
   logic [W-1:0]          rd_data;
   logic                  req_accept;
   logic [CountWidth-1:0] k_new;
   logic                  store_full;

   assign req_accept = req_chan.valid && req_chan.ready;
   // start_req empties the store before this modulus is taken
   assign k_new      = req_chan.start_req ? '0 : count_ff;
   assign store_full = (k_new >= CountWidth'(MAX_MODULI));
   // write the new modulus right away: only entries below it are read later
   assign wr_en      = req_accept && !store_full;
   assign wr_addr    = k_new[AddrWidth-1:0];

   rgc_ram #(
      .DATA_WIDTH (W),
      .DEPTH      (MAX_MODULI)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.modulus),
      .rd_addr (idx_ff[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // Shared restoring divider: one quotient bit per cycle
   // ------------------------------------------------------------------
   logic [W-1:0] divisor;
   logic [W:0]   div_shift;
   logic [W:0]   div_diff;
   logic         div_ge;
   logic [W-1:0] rem_step;

   assign divisor   = phase_ff ? r1_ff : p_ff;
   assign div_shift = {rem_ff, dq_ff[DivWidth-1]};
   assign div_diff  = div_shift - {1'b0, divisor};
   assign div_ge    = (div_shift >= {1'b0, divisor});
   assign rem_step  = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];

   // ------------------------------------------------------------------
   // Shared multiplier: product * stored modulus, or quotient * t1
   // ------------------------------------------------------------------
   logic signed [W:0]        mul_a;
   logic signed [TWidth-1:0] mul_b;

   assign mul_a   = (state_ff == S_MUL) ? $signed({1'b0, rd_data})
                                        : $signed({1'b0, dq_ff[W-1:0]});
   assign mul_b   = (state_ff == S_MUL) ? $signed({2'b00, prod_ff}) : t1_ff;
   assign mult_in = ProdWidth'(mul_a) * ProdWidth'(mul_b);

   logic                     last_factor;
   logic signed [TWidth-1:0] p_signed;
   logic                     out_free;

   assign last_factor = ((idx_ff + CountWidth'(1)) == k_ff);
   assign p_signed    = $signed({2'b00, p_ff});
   assign out_free    = !out_valid_ff || rsp_chan.ready;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      phase_in     = phase_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      res_recip_in = res_recip_ff;
      res_err_in   = res_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               p_in         = req_chan.modulus;
               k_in         = k_new;
               idx_in       = '0;
               prod_in      = W'(1);
               res_recip_in = '0;
               res_err_in   = rgc_pkg::ERR_OK;
               if (store_full) begin
                  // drop the modulus, report position 0
                  k_in       = '0;
                  res_err_in = rgc_pkg::ERR_STORE_FULL;
                  state_in   = S_DONE;
               end else begin
                  count_in = k_new + CountWidth'(1);
                  if (k_new == '0) begin
                     state_in = S_DONE;
                  end else if (req_chan.modulus == '0) begin
                     res_err_in = rgc_pkg::ERR_NO_INVERSE;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            // store read address is idx; data shows up next cycle
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_RLOAD;
         end
         S_RLOAD: begin
            dq_in    = mult_ff[DivWidth-1:0];
            rem_in   = '0;
            dcnt_in  = StepWidth'(DivWidth);
            phase_in = 1'b0;
            state_in = S_DIV;
         end
         S_DIV: begin
            dq_in   = {dq_ff[DivWidth-2:0], div_ge};
            rem_in  = rem_step;
            dcnt_in = dcnt_ff - StepWidth'(1);
            if (dcnt_ff == StepWidth'(1)) begin
               state_in = phase_ff ? S_EUMUL : S_RDONE;
            end
         end
         S_RDONE: begin
            prod_in = rem_ff;
            if (last_factor) begin
               // begin extended Euclid on (p, product)
               r0_in    = p_ff;
               r1_in    = rem_ff;
               t0_in    = '0;
               t1_in    = TWidth'(1);
               state_in = S_EUCHK;
            end else begin
               idx_in   = idx_ff + CountWidth'(1);
               state_in = S_READ;
            end
         end
         S_EUCHK: begin
            if (r1_ff == '0) begin
               if (r0_ff == W'(1)) begin
                  state_in = S_FIN1;
               end else begin
                  res_err_in = rgc_pkg::ERR_NO_INVERSE;
                  state_in   = S_DONE;
               end
            end else begin
               dq_in    = {r0_ff, {W{1'b0}}};
               rem_in   = '0;
               dcnt_in  = StepWidth'(W);
               phase_in = 1'b1;
               state_in = S_DIV;
            end
         end
         S_EUMUL: begin
            // quotient sits in dq low half; multiplier forms q * t1 this cycle
            r0_in    = r1_ff;
            r1_in    = rem_ff;
            state_in = S_EUUPD;
         end
         S_EUUPD: begin
            t0_in    = t1_ff;
            t1_in    = t0_ff - $signed(mult_ff[TWidth-1:0]);
            state_in = S_EUCHK;
         end
         S_FIN1: begin
            if (t0_ff < 0) begin
               t0_in = t0_ff + p_signed;
            end
            state_in = S_FIN2;
         end
         S_FIN2: begin
            res_recip_in = (t0_ff >= p_signed) ? '0 : t0_ff[W-1:0];
            res_err_in   = rgc_pkg::ERR_OK;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output register: parts the response side from the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      out_recip_in = out_recip_ff;
      out_pos_in   = out_pos_ff;
      out_err_in   = out_err_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == S_DONE) && out_free) begin
         out_valid_in = 1'b1;
         out_recip_in = res_recip_ff;
         out_pos_in   = PosWidth'(k_ff);
         out_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff         <= k_in;
      p_ff         <= p_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      mult_ff      <= mult_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      phase_ff     <= phase_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      res_recip_ff <= res_recip_in;
      res_err_ff   <= res_err_in;
      out_recip_ff <= out_recip_in;
      out_pos_ff   <= out_pos_in;
      out_err_ff   <= out_err_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.reciprocal = out_recip_ff;
   assign rsp_chan.position   = out_pos_ff;
   assign rsp_chan.error      = out_err_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (divisor != '0))
      else $error("divider running with a zero divisor");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MAX_MODULI))
      else $error("modulus count beyond store depth");

   a_start_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.start_req) |=> (count_ff == CountWidth'(1)))
      else $error("new system did not restart the modulus count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_err_ff != rgc_pkg::ERR_OK)) |-> (out_recip_ff == '0))
      else $error("error result carries a nonzero reciprocal");

endmodule

// ===== bench/rgc_coeff_checker.sv =====
// Scoreboard for the RNS Garner coefficient unit: watches both channels, predicts each
// coefficient from its own modulus store and compares every response field.
// Depends on rgc_pkg, rgc_req_if and rgc_rsp_if.
module rgc_coeff_checker #(
   parameter int MAX_MODULI    = rgc_pkg::MAX_MODULI,
   parameter int MODULUS_WIDTH = rgc_pkg::MODULUS_WIDTH
) (
   input  logic clock,
   input  logic reset,
   rgc_req_if   req_mon,
   rgc_rsp_if   rsp_mon,
   output int   mismatch_total,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [MODULUS_WIDTH-1:0]          reciprocal;
      logic [rgc_pkg::POS_WIDTH-1:0]     position;
      logic [rgc_pkg::ERR_WIDTH-1:0]     error;
   } coeff_result_type;

   logic [MODULUS_WIDTH-1:0] system_moduli [MAX_MODULI];
   int                       system_size;
   coeff_result_type         coeff_expected [$];
   int                       response_index;

   initial begin
      mismatch_total  = 0;
      pending_results = 0;
      system_size     = 0;
      response_index  = 0;
   end

   task automatic report_mismatch(input string field, input longint got, input longint want);
      // keep counting past the print cap so the verdict still sees every failure
      if (mismatch_total < PRINT_CAP)
         $display("%0t ns response %0d: %s got %0d, want %0d",
                  $time, response_index, field, got, want);
      mismatch_total++;
   endtask

   // Extended Euclid; returns 0 when gcd(a, p) is not 1.
   function automatic bit invert_mod(input longint a, input longint p, output longint inv);
      longint r_prev, r_cur, s_prev, s_cur, q, tmp;
      r_prev = p;
      r_cur  = a;
      s_prev = 0;
      s_cur  = 1;
      while (r_cur != 0) begin
         q      = r_prev / r_cur;
         tmp    = r_prev - q * r_cur;
         r_prev = r_cur;
         r_cur  = tmp;
         tmp    = s_prev - q * s_cur;
         s_prev = s_cur;
         s_cur  = tmp;
      end
      inv = 0;
      if (r_prev != 1)
         return 0;
      if (s_prev < 0)
         s_prev += p;
      inv = s_prev % p;
      return 1;
   endfunction

   task automatic predict_coefficient(input logic [MODULUS_WIDTH-1:0] p, input logic start,
                                      output coeff_result_type res);
      longint pw, prod, factor, inv;
      int     k;
      res.reciprocal = '0;
      res.position   = '0;
      res.error      = rgc_pkg::ERR_OK;
      pw = longint'({1'b0, p});
      if (start)
         system_size = 0;
      if (system_size >= MAX_MODULI) begin
         res.error = rgc_pkg::ERR_STORE_FULL;
      end else begin
         k = system_size;
         res.position = k[rgc_pkg::POS_WIDTH-1:0];
         if (k > 0) begin
            if (pw == 0) begin
               res.error = rgc_pkg::ERR_NO_INVERSE;
            end else begin
               prod = longint'({1'b0, system_moduli[0]}) % pw;
               for (int i = 1; i < k; i++) begin
                  factor = longint'({1'b0, system_moduli[i]}) % pw;
                  prod   = (prod * factor) % pw;
               end
               if (invert_mod(prod, pw, inv))
                  res.reciprocal = inv[MODULUS_WIDTH-1:0];
               else
                  res.error = rgc_pkg::ERR_NO_INVERSE;
            end
         end
         system_moduli[k] = p;
         system_size      = k + 1;
      end
   endtask

   always @(posedge clock) begin
      coeff_result_type want;
      coeff_result_type fresh;
      if (reset) begin
         system_size = 0;
         coeff_expected.delete();
      end else begin
         // retire the response first: it can only belong to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (coeff_expected.size() == 0) begin
               report_mismatch("unexpected response, position", rsp_mon.position, -1);
            end else begin
               want = coeff_expected.pop_front();
               if (rsp_mon.reciprocal !== want.reciprocal)
                  report_mismatch("reciprocal", rsp_mon.reciprocal, want.reciprocal);
               if (rsp_mon.position !== want.position)
                  report_mismatch("position", rsp_mon.position, want.position);
               if (rsp_mon.error !== want.error)
                  report_mismatch("error", rsp_mon.error, want.error);
            end
            response_index++;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_coefficient(req_mon.modulus, req_mon.start_req, fresh);
            coeff_expected.push_back(fresh);
         end
      end
      pending_results <= coeff_expected.size();
   end

endmodule

// ===== bench/rns_garner_coefficients_top_tb.sv =====
// Testbench top for the RNS Garner coefficient unit: clock, reset, request and response
// traffic with random idling, and the final verdict. Depends on rgc_pkg, rgc_req_if,
// rgc_rsp_if, rgc_coeff_checker and the unit itself.
module rns_garner_coefficients_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 900;
   // deepest item: 63 product folds plus the longest Euclid run, with margin
   localparam int DRAIN_CYCLES  = 3500;
   localparam int MAX_IDLE      = 11;

   logic clock = 1'b0;
   logic reset;

   int   mismatch_total;
   int   pending_results;
   bit   no_idle;
   int   items_sent;

   logic [rgc_pkg::MODULUS_WIDTH-1:0] open_system [$];

   rgc_req_if req_chan ();
   rgc_rsp_if rsp_chan ();

   rns_garner_coefficients_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rgc_coeff_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_total  (mismatch_total),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gcd16(input int a, input int b);
      int t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Draw a modulus coprime to everything already in the open system, so the
   // sequence stays well formed and most coefficients come out without error.
   function automatic logic [rgc_pkg::MODULUS_WIDTH-1:0] pick_coprime_modulus();
      int cand;
      bit clean;
      cand = 2;
      repeat (24) begin
         if ($urandom_range(9, 0) < 3)
            cand = $urandom_range(255, 2);
         else
            cand = $urandom_range(65535, 2);
         clean = 1'b1;
         foreach (open_system[i])
            if (gcd16(cand, int'(open_system[i])) != 1)
               clean = 1'b0;
         if (clean)
            return cand[rgc_pkg::MODULUS_WIDTH-1:0];
      end
      return cand[rgc_pkg::MODULUS_WIDTH-1:0];
   endfunction

   // Break the sequence: zero, one, a repeat, an even multiple or raw noise.
   function automatic logic [rgc_pkg::MODULUS_WIDTH-1:0] pick_broken_modulus();
      logic [rgc_pkg::MODULUS_WIDTH-1:0] prev;
      prev = (open_system.size() > 0) ?
             open_system[$urandom_range(open_system.size() - 1, 0)] : 16'd6;
      case ($urandom_range(4, 0))
         0:       return '0;
         1:       return 16'd1;
         2:       return prev;
         3:       return prev << 1;
         default: return rgc_pkg::MODULUS_WIDTH'($urandom_range(65535, 0));
      endcase
   endfunction

   // Present one modulus and hold it until the unit takes the transaction.
   // Entered and left in the time step of a rising edge; valid stays high
   // across back-to-back transactions instead of dropping for a step.
   task automatic send_modulus(input logic [rgc_pkg::MODULUS_WIDTH-1:0] p, input logic start);
      int gap;
      gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.modulus   <= p;
      req_chan.start_req <= start;
      // ready is settled by the falling edge; the next rising edge accepts
      @(negedge clock);
      while (!req_chan.ready)
         @(negedge clock);
      @(posedge clock);
      if (start)
         open_system.delete();
      open_system.push_back(p);
      items_sent++;
   endtask

   // Response side: stall a random number of cycles, then take one transaction.
   task automatic take_results();
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_chan.valid)
            @(negedge clock);
         @(posedge clock);
      end
   endtask

   task automatic run_directed();
      // first modulus after reset needs no start; any value gives 0 at position 0
      send_modulus(16'hFFFF, 1'b0);
      send_modulus(16'd65521, 1'b0);
      send_modulus(16'd2, 1'b0);
      send_modulus(16'd1, 1'b0);        // modulus one: everything reduces to 0
      send_modulus(16'd0, 1'b0);        // zero later on: no inverse
      send_modulus(16'd4, 1'b0);        // shares a factor with 2
      send_modulus(16'd3, 1'b0);
      send_modulus(16'd65519, 1'b0);
      // zero as the first modulus, then anything fails to invert
      send_modulus(16'd0, 1'b1);
      send_modulus(16'd7, 1'b0);
      send_modulus(16'd65535, 1'b0);
      // modulus one first: it leaves the product unchanged
      send_modulus(16'd1, 1'b1);
      send_modulus(16'hFFFF, 1'b0);
      send_modulus(16'd32768, 1'b0);
      // top of the range, then a neighbor and a power of two
      send_modulus(16'hFFFF, 1'b1);
      send_modulus(16'hFFFE, 1'b0);
      send_modulus(16'h8000, 1'b0);
      send_modulus(16'h7FFF, 1'b0);
      // inverse of 2 modulo the largest odd value
      send_modulus(16'd2, 1'b1);
      send_modulus(16'hFFFF, 1'b0);
      send_modulus(16'h5555, 1'b0);
      send_modulus(16'hAAAA, 1'b0);
      send_modulus(16'd65521, 1'b0);
   endtask

   task automatic run_random();
      int  system_idx;
      int  len;
      bit  fill_store;
      logic [rgc_pkg::MODULUS_WIDTH-1:0] p;
      system_idx = 0;
      while (items_sent < RANDOM_ITEMS) begin
         // a few systems run the store past full; the rest stay short and fast
         fill_store = (system_idx % 50 == 7);
         if (fill_store)
            len = rgc_pkg::MAX_MODULI + $urandom_range(3, 1);
         else if ($urandom_range(9, 0) == 0)
            len = $urandom_range(30, 11);
         else
            len = $urandom_range(10, 1);
         no_idle = ($urandom_range(5, 0) == 0);
         for (int j = 0; j < len; j++) begin
            if (!fill_store && j > 0 && $urandom_range(99, 0) < 15)
               p = pick_broken_modulus();
            else
               p = pick_coprime_modulus();
            send_modulus(p, j == 0);
         end
         system_idx++;
      end
   endtask

   initial begin
      // drive every input to a known value before the first edge
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.modulus   <= '0;
      req_chan.start_req <= 1'b0;
      rsp_chan.ready     <= 1'b0;
      no_idle             = 1'b0;
      items_sent          = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         take_results();
      join_none

      run_directed();
      items_sent = 0;
      run_random();
      req_chan.valid <= 1'b0;

      // drain outstanding coefficients, then watch for stray responses
      while (pending_results != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0 && pending_results == 0)
         $display("rns_garner_coefficients_top verification clean");
      else
         $display("rns_garner_coefficients_top verification failed");
      $finish;
   end

   // hang guard: several times the slowest legal run
   initial begin
      #100_000_000;
      $display("rns_garner_coefficients_top verification failed");
      $finish;
   end

endmodule
